// ----- rtl/camera_point_projection_unit_macros.svh -----
// Assertion macros shared by the camera point projection RTL.
`ifndef CAMERA_POINT_PROJECTION_UNIT_MACROS_SVH
`define CAMERA_POINT_PROJECTION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPPU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("camera point projection check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("camera point projection check failed");

`endif

// ----- rtl/cppu_pkg.sv -----
// Types, constants and saturating arithmetic for the camera point projection unit.
package cppu_pkg;

  localparam int FRAC       = 30;
  localparam int COEF_FRAC  = 28;
  localparam int MUL_LAT    = 4;
  localparam int DIV_STEPS  = 63;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] FIX_ONE = 64'sh0000_0000_4000_0000;
  localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_MIN = -SUM_MAX;

  // A Q.30 intermediate together with the saturation history of everything behind it.
  typedef struct packed {
    logic               clip;
    logic signed [63:0] val;
  } fix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X = 3'd0,
    REG_FOCAL_Y = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_RADIAL_K1 = 3'd4,
    REG_RADIAL_K2 = 3'd5,
    REG_TANGENTIAL_P1 = 3'd6,
    REG_TANGENTIAL_P2 = 3'd7
  } cfg_reg_e;

  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic signed [64:0] s;
    fix_t r;
    s = 65'(a.val) + 65'(b.val);
    r.clip = a.clip | b.clip;
    if (s > SUM_MAX) begin
      r.val = SAT_MAX;
      r.clip = 1'b1;
    end else if (s < SUM_MIN) begin
      r.val = -SAT_MAX;
      r.clip = 1'b1;
    end else begin
      r.val = s[63:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/cppu_delay.sv -----
// Stallable shift line that delays a word through DEPTH registers.
module cppu_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// ----- rtl/cppu_mul.sv -----
// Four-stage signed 64x64 multiplier with rounding shift and saturation.
module cppu_mul #(
  parameter int SHIFT = 30
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  cppu_pkg::fix_t a_i,
  input  cppu_pkg::fix_t b_i,
  output cppu_pkg::fix_t p_o
);
  import cppu_pkg::*;

  localparam logic [127:0] HALF = 128'd1 << (SHIFT - 1);

  logic [63:0]  mag_a_d, mag_b_d, mag_a_q, mag_b_q;
  logic         neg1_q, clip1_q;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic         neg2_q, clip2_q;
  logic [127:0] sum_d, sum_q;
  logic         neg3_q, clip3_q;
  logic [127:0] shifted;
  logic         over;
  logic [62:0]  mag_r;
  fix_t         p_d, p_q;

  always_comb begin
    mag_a_d = a_i.val[63] ? $unsigned(-a_i.val) : $unsigned(a_i.val);
    mag_b_d = b_i.val[63] ? $unsigned(-b_i.val) : $unsigned(b_i.val);
    sum_d = {hh_q, ll_q} + {32'b0, lh_q, 32'b0} + {32'b0, hl_q, 32'b0} + HALF;
    shifted = sum_q >> SHIFT;
    over = |shifted[127:63];
    mag_r = over ? SAT_MAX[62:0] : shifted[62:0];
    p_d.clip = clip3_q | over;
    p_d.val = neg3_q ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= mag_a_d;
      mag_b_q <= mag_b_d;
      neg1_q  <= a_i.val[63] ^ b_i.val[63];
      clip1_q <= a_i.clip | b_i.clip;
      ll_q    <= 64'(mag_a_q[31:0]) * 64'(mag_b_q[31:0]);
      lh_q    <= 64'(mag_a_q[31:0]) * 64'(mag_b_q[63:32]);
      hl_q    <= 64'(mag_a_q[63:32]) * 64'(mag_b_q[31:0]);
      hh_q    <= 64'(mag_a_q[63:32]) * 64'(mag_b_q[63:32]);
      neg2_q  <= neg1_q;
      clip2_q <= clip1_q;
      sum_q   <= sum_d;
      neg3_q  <= neg2_q;
      clip3_q <= clip2_q;
      p_q     <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/cppu_div.sv -----
// Pipelined restoring divider producing x/z and y/z in Q.30, one quotient bit per stage.
module cppu_div #(
  parameter int WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WIDTH-1:0] x_i,
  input  logic signed [WIDTH-1:0] y_i,
  input  logic signed [WIDTH-1:0] z_i,
  output cppu_pkg::fix_t          u_o,
  output cppu_pkg::fix_t          v_o
);
  import cppu_pkg::*;

  localparam int NUM_W = WIDTH + 64;

  logic signed [WIDTH-1:0] num_in [2];
  logic [WIDTH-1:0]        mag_in [2];
  logic [NUM_W-1:0]        num_ext [2];
  logic                    sat_in [2];

  logic [WIDTH-1:0] den_q [DIV_STEPS];
  logic [WIDTH-1:0] rem_q [2][DIV_STEPS];
  logic [62:0]      qn_q  [2][DIV_STEPS+1];
  logic             sat_q [2][DIV_STEPS+1];
  logic             neg_q [2][DIV_STEPS+1];

  logic [WIDTH-1:0] t_w  [2][DIV_STEPS];
  logic             ge_w [2][DIV_STEPS];

  logic [62:0] q_fin [2];
  fix_t        res_d [2];
  fix_t        res_q [2];

  assign num_in[0] = x_i;
  assign num_in[1] = y_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag_in[l] = num_in[l][WIDTH-1] ? $unsigned(-num_in[l]) : $unsigned(num_in[l]);
      num_ext[l] = NUM_W'(mag_in[l]) << FRAC;
      sat_in[l] = {33'b0, mag_in[l]} >= {$unsigned(z_i), 33'b0};
      for (int s = 0; s < DIV_STEPS; s++) begin
        t_w[l][s] = {rem_q[l][s][WIDTH-2:0], qn_q[l][s][62]};
        ge_w[l][s] = t_w[l][s] >= den_q[s];
      end
      q_fin[l] = sat_q[l][DIV_STEPS] ? SAT_MAX[62:0] : qn_q[l][DIV_STEPS];
      res_d[l].clip = sat_q[l][DIV_STEPS];
      res_d[l].val = neg_q[l][DIV_STEPS] ? -$signed({1'b0, q_fin[l]})
                                         : $signed({1'b0, q_fin[l]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= $unsigned(z_i);
      for (int s = 1; s < DIV_STEPS; s++) begin
        den_q[s] <= den_q[s-1];
      end
      for (int l = 0; l < 2; l++) begin
        rem_q[l][0] <= WIDTH'(num_ext[l] >> 63);
        qn_q[l][0]  <= num_ext[l][62:0];
        sat_q[l][0] <= sat_in[l];
        neg_q[l][0] <= num_in[l][WIDTH-1];
        for (int s = 1; s < DIV_STEPS; s++) begin
          rem_q[l][s] <= ge_w[l][s-1] ? t_w[l][s-1] - den_q[s-1] : t_w[l][s-1];
        end
        for (int s = 1; s <= DIV_STEPS; s++) begin
          qn_q[l][s]  <= {qn_q[l][s-1][61:0], ge_w[l][s-1]};
          sat_q[l][s] <= sat_q[l][s-1];
          neg_q[l][s] <= neg_q[l][s-1];
        end
        res_q[l] <= res_d[l];
      end
    end
  end

  assign u_o = res_q[0];
  assign v_o = res_q[1];

endmodule

// ----- rtl/camera_point_projection_unit.sv -----
// Top level of the pinhole camera projection unit with radial and tangential lens distortion.
// The unit takes one point per cycle and returns its pixel word after the divider (one
// quotient bit per stage, 63 stages plus setup and sign stages) and five rounds of
// four-stage multipliers with the saturating adds between them. When the output word is
// not taken the whole pipeline holds, so no word is lost or repeated. Configuration must be
// written through the plain write port while no point is in flight; the block itself does
// not enforce this. Configuration needs no setup pass.
module camera_point_projection_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]      point_x_i,
  input  logic signed [COORD_WIDTH-1:0]      point_y_i,
  input  logic signed [COORD_WIDTH-1:0]      point_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [COORD_WIDTH-1:0]      pixel_u_o,
  output logic signed [COORD_WIDTH-1:0]      pixel_v_o,
  output logic                               in_front_o,
  output logic                               clipped_o,
  input  logic                               cfg_we_i,
  input  logic [cppu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cppu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import cppu_pkg::*;

  `include "camera_point_projection_unit_macros.svh"

  localparam int TOTAL      = DIV_LAT + 5 * MUL_LAT + 5;
  localparam int FIX_W      = $bits(fix_t);
  localparam int DR1_DEPTH  = MUL_LAT - 1;
  localparam int DT_DEPTH   = 2 * MUL_LAT - 1;
  localparam int NRM_DEPTH  = 3 * MUL_LAT + 2;
  localparam logic signed [63:0] COORD_MAX = 64'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [63:0] COORD_MIN = -COORD_MAX - 64'sd1;

  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [31:0] radial_k1_q, radial_k2_q, tangential_p1_q, tangential_p2_q;

  logic             en;
  logic [TOTAL-1:0] valid_q;
  logic             front_in, front_d;

  fix_t k1_f, k2_f, p1_f, p2_f, fx_f, fy_f, cx_f, cy_f, one_f;
  fix_t nu, nv, uu, vv, uv;
  fix_t r_q, uv2_q, uu2_q, vv2_q;
  fix_t r2, k1r, uv2p1, uv2p2;
  fix_t ru2_q, rv2_q, ru2p2, rv2p1, k2r2;
  fix_t dr1_q, uv2p1_d, uv2p2_d, dtx_q, dty_q, dr1_d, dr_q;
  fix_t nu_d, nv_d, du, dv, dtx_d, dty_d, dx_q, dy_q;
  fix_t fu, fv, pu_q, pv_q;

  logic signed [63:0]            pu_c, pv_c;
  logic                          cu, cv;
  logic signed [COORD_WIDTH-1:0] pixel_u_d, pixel_v_d, pixel_u_q, pixel_v_q;
  logic                          in_front_q, clipped_d, clipped_q;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign front_in   = (point_z_i > 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q       <= 32'd65536;
      focal_y_q       <= 32'd65536;
      center_x_q      <= '0;
      center_y_q      <= '0;
      radial_k1_q     <= '0;
      radial_k2_q     <= '0;
      tangential_p1_q <= '0;
      tangential_p2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FOCAL_X:       focal_x_q       <= cfg_data_i;
        REG_FOCAL_Y:       focal_y_q       <= cfg_data_i;
        REG_CENTER_X:      center_x_q      <= cfg_data_i;
        REG_CENTER_Y:      center_y_q      <= cfg_data_i;
        REG_RADIAL_K1:     radial_k1_q     <= cfg_data_i;
        REG_RADIAL_K2:     radial_k2_q     <= cfg_data_i;
        REG_TANGENTIAL_P1: tangential_p1_q <= cfg_data_i;
        REG_TANGENTIAL_P2: tangential_p2_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[TOTAL-2:0], in_valid_i};
    end
  end

  assign out_valid_o = valid_q[TOTAL-1];

  assign k1_f  = '{clip: 1'b0, val: 64'($signed(radial_k1_q))};
  assign k2_f  = '{clip: 1'b0, val: 64'($signed(radial_k2_q))};
  assign p1_f  = '{clip: 1'b0, val: 64'($signed(tangential_p1_q))};
  assign p2_f  = '{clip: 1'b0, val: 64'($signed(tangential_p2_q))};
  assign fx_f  = '{clip: 1'b0, val: $signed({32'b0, focal_x_q})};
  assign fy_f  = '{clip: 1'b0, val: $signed({32'b0, focal_y_q})};
  assign cx_f  = '{clip: 1'b0, val: $signed({32'b0, center_x_q})};
  assign cy_f  = '{clip: 1'b0, val: $signed({32'b0, center_y_q})};
  assign one_f = '{clip: 1'b0, val: FIX_ONE};

  cppu_div #(.WIDTH(COORD_WIDTH)) u_div (
    .clk_i, .en_i(en), .x_i(point_x_i), .y_i(point_y_i), .z_i(point_z_i),
    .u_o(nu), .v_o(nv)
  );

  cppu_mul #(.SHIFT(FRAC)) u_mul_uu (.clk_i, .en_i(en), .a_i(nu), .b_i(nu), .p_o(uu));
  cppu_mul #(.SHIFT(FRAC)) u_mul_vv (.clk_i, .en_i(en), .a_i(nv), .b_i(nv), .p_o(vv));
  cppu_mul #(.SHIFT(FRAC)) u_mul_uv (.clk_i, .en_i(en), .a_i(nu), .b_i(nv), .p_o(uv));

  cppu_mul #(.SHIFT(FRAC)) u_mul_r2 (.clk_i, .en_i(en), .a_i(r_q), .b_i(r_q), .p_o(r2));
  cppu_mul #(.SHIFT(COEF_FRAC)) u_mul_k1r (
    .clk_i, .en_i(en), .a_i(k1_f), .b_i(r_q), .p_o(k1r)
  );
  cppu_mul #(.SHIFT(COEF_FRAC)) u_mul_uv2p1 (
    .clk_i, .en_i(en), .a_i(uv2_q), .b_i(p1_f), .p_o(uv2p1)
  );
  cppu_mul #(.SHIFT(COEF_FRAC)) u_mul_uv2p2 (
    .clk_i, .en_i(en), .a_i(uv2_q), .b_i(p2_f), .p_o(uv2p2)
  );
  cppu_mul #(.SHIFT(COEF_FRAC)) u_mul_ru2p2 (
    .clk_i, .en_i(en), .a_i(ru2_q), .b_i(p2_f), .p_o(ru2p2)
  );
  cppu_mul #(.SHIFT(COEF_FRAC)) u_mul_rv2p1 (
    .clk_i, .en_i(en), .a_i(rv2_q), .b_i(p1_f), .p_o(rv2p1)
  );
  cppu_mul #(.SHIFT(COEF_FRAC)) u_mul_k2r2 (
    .clk_i, .en_i(en), .a_i(k2_f), .b_i(r2), .p_o(k2r2)
  );
  cppu_mul #(.SHIFT(FRAC)) u_mul_du (.clk_i, .en_i(en), .a_i(dr_q), .b_i(nu_d), .p_o(du));
  cppu_mul #(.SHIFT(FRAC)) u_mul_dv (.clk_i, .en_i(en), .a_i(dr_q), .b_i(nv_d), .p_o(dv));
  cppu_mul #(.SHIFT(FRAC)) u_mul_fu (.clk_i, .en_i(en), .a_i(fx_f), .b_i(dx_q), .p_o(fu));
  cppu_mul #(.SHIFT(FRAC)) u_mul_fv (.clk_i, .en_i(en), .a_i(fy_f), .b_i(dy_q), .p_o(fv));

  cppu_delay #(.WIDTH(FIX_W), .DEPTH(1)) u_dly_uv2p1 (
    .clk_i, .en_i(en), .d_i(uv2p1), .q_o(uv2p1_d)
  );
  cppu_delay #(.WIDTH(FIX_W), .DEPTH(1)) u_dly_uv2p2 (
    .clk_i, .en_i(en), .d_i(uv2p2), .q_o(uv2p2_d)
  );
  cppu_delay #(.WIDTH(FIX_W), .DEPTH(DR1_DEPTH)) u_dly_dr1 (
    .clk_i, .en_i(en), .d_i(dr1_q), .q_o(dr1_d)
  );
  cppu_delay #(.WIDTH(FIX_W), .DEPTH(DT_DEPTH)) u_dly_dtx (
    .clk_i, .en_i(en), .d_i(dtx_q), .q_o(dtx_d)
  );
  cppu_delay #(.WIDTH(FIX_W), .DEPTH(DT_DEPTH)) u_dly_dty (
    .clk_i, .en_i(en), .d_i(dty_q), .q_o(dty_d)
  );
  cppu_delay #(.WIDTH(FIX_W), .DEPTH(NRM_DEPTH)) u_dly_nu (
    .clk_i, .en_i(en), .d_i(nu), .q_o(nu_d)
  );
  cppu_delay #(.WIDTH(FIX_W), .DEPTH(NRM_DEPTH)) u_dly_nv (
    .clk_i, .en_i(en), .d_i(nv), .q_o(nv_d)
  );
  cppu_delay #(.WIDTH(1), .DEPTH(TOTAL - 1)) u_dly_front (
    .clk_i, .en_i(en), .d_i(front_in), .q_o(front_d)
  );

  always_comb begin
    pu_c = pu_q.val;
    pv_c = pv_q.val;
    cu = 1'b0;
    cv = 1'b0;
    if (pu_q.val > COORD_MAX) begin
      pu_c = COORD_MAX;
      cu = 1'b1;
    end else if (pu_q.val < COORD_MIN) begin
      pu_c = COORD_MIN;
      cu = 1'b1;
    end
    if (pv_q.val > COORD_MAX) begin
      pv_c = COORD_MAX;
      cv = 1'b1;
    end else if (pv_q.val < COORD_MIN) begin
      pv_c = COORD_MIN;
      cv = 1'b1;
    end
    pixel_u_d = front_d ? pu_c[COORD_WIDTH-1:0] : '0;
    pixel_v_d = front_d ? pv_c[COORD_WIDTH-1:0] : '0;
    clipped_d = front_d & (pu_q.clip | pv_q.clip | cu | cv);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q        <= sat_add(uu, vv);
      uv2_q      <= sat_add(uv, uv);
      uu2_q      <= sat_add(uu, uu);
      vv2_q      <= sat_add(vv, vv);
      ru2_q      <= sat_add(r_q, uu2_q);
      rv2_q      <= sat_add(r_q, vv2_q);
      dr1_q      <= sat_add(one_f, k1r);
      dtx_q      <= sat_add(uv2p1_d, ru2p2);
      dty_q      <= sat_add(uv2p2_d, rv2p1);
      dr_q       <= sat_add(dr1_d, k2r2);
      dx_q       <= sat_add(du, dtx_d);
      dy_q       <= sat_add(dv, dty_d);
      pu_q       <= sat_add(fu, cx_f);
      pv_q       <= sat_add(fv, cy_f);
      pixel_u_q  <= pixel_u_d;
      pixel_v_q  <= pixel_v_d;
      in_front_q <= front_d;
      clipped_q  <= clipped_d;
    end
  end

  assign pixel_u_o  = pixel_u_q;
  assign pixel_v_o  = pixel_v_q;
  assign in_front_o = in_front_q;
  assign clipped_o  = clipped_q;

  `CPPU_ASSERT_NOW(a_behind_is_zero, clk_i, rst_ni, out_valid_o && !in_front_o,
                   !clipped_o && pixel_u_o == 0 && pixel_v_o == 0)
  `CPPU_ASSERT_NEXT(a_stall_holds_pipe, clk_i, rst_ni, !in_ready_o, $stable(valid_q))
  `CPPU_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_valid_i && in_ready_o, valid_q[0])

endmodule
